// File: hdl/pht_pkg.sv
// ----------------------------------------------------------------------------
// pht_pkg: shared types and constants of the probing hash table
// Payload structs, opcodes, probe offsets and the command/status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package pht_pkg;

   localparam int KEY_W   = 31;
   localparam int SIZE_W  = 11;
   localparam int POS_W   = 10;
   localparam int ATT_W   = 13;
   localparam int DCNT_W  = 5;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
   localparam logic [31:0]       PHI_INV_Q32 = 32'd2654435769;
   localparam logic [DCNT_W-1:0] DIV_LAST   = 5'd30;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   typedef enum logic [1:0] {
      OFF_CENTRE = 2'd0,
      OFF_RIGHT  = 2'd1,
      OFF_LEFT   = 2'd2
   } offset_type;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic             success;
      logic [POS_W-1:0] position;
   } rsp_type;

   typedef struct packed {
      logic       load_req;
      logic       clr_step;
      logic       div_start;
      logic       div_step;
      logic       advance;
      logic       mul1;
      logic       mul2;
      logic       mul3;
      logic       off_load;
      offset_type off_value;
      logic       mem_rd;
      logic       mem_wr_key;
      logic       load_rsp;
      logic       rsp_ok;
      logic       rsp_pos;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       clr_last;
      logic       div_last;
      logic       match;
      logic       has_right;
      logic       has_left;
      logic       last_attempt;
      offset_type off;
      logic       rsp_busy;
   } status_type;

endpackage

// File: hdl/probing_hash_table.sv
// ----------------------------------------------------------------------------
// probing_hash_table: open-addressing hash table of 31-bit keys
// Clear, insert and search over a slot memory with multiplicative and
// linear probing; one response beat per request beat.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall, req_data) carries opcode and key; one
//   request is worked at a time, req_stall is high while busy.
//   rsp channel (rsp_valid/rsp_stall, rsp_data) returns success and position
//   from an output register; the next request is taken while a beat waits.
//   csr_wr_en/csr_wr_data set the slot count S; write only while idle.
// Sequence (accept to response valid):
//   clear: one slot per cycle through the memory port, then the result.
//   insert/search: dispatch, then form key mod S (one key bit per cycle),
//   then per attempt advance, MUL1, MUL2, MUL3, read and check, plus a read
//   and check per neighbour probe, up to 3*S/2 attempts, then load the result;
//   the single read port sets the pace. Unknown opcode: result, success 0.
// The next request can be accepted in the cycle after the result loads.
// Reset: sweeps all TABLE_SIZE slots empty with req_stall high; S returns
//   to 1024.
// Stall: a stalled response beat holds; a finished result waits in the
//   controller until the output register frees.
// ----------------------------------------------------------------------------
module probing_hash_table
   import pht_pkg::*;
#(
   parameter int TABLE_SIZE = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   pht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   pht_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

// File: hdl/pht_datapath.sv
// ----------------------------------------------------------------------------
// pht_datapath: slot memory, hash arithmetic and result register
// Holds the size register, key mod S divider, three-stage multiplicative
// hash, probe addressing, the slot memory and the output beat register.
// ----------------------------------------------------------------------------
module pht_datapath
   import pht_pkg::*;
#(
   parameter int TABLE_SIZE = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  req_type          req_data,
   input  logic             csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int AW    = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;
   localparam int CAP_INT = (TABLE_SIZE > 2047) ? 2047 : TABLE_SIZE;
   localparam logic [SIZE_W-1:0] SIZE_CAP = CAP_INT[SIZE_W-1:0];
   localparam logic [IDX_W-1:0]  CLR_LAST = IDX_W'(TABLE_SIZE - 1);

   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] s_use, half;
   logic [ATT_W-1:0]  last;
   logic [1:0]        op_ff;
   logic [KEY_W-1:0]  key_ff, kshift_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W:0]   rem_shift, r_inc;
   logic [ATT_W-1:0]  a_ff;
   logic [31:0]       ka_ff, frac_ff;
   logic [43:0]       ka_full;
   logic [63:0]       frac_full;
   logic [42:0]       pos_full;
   logic [SIZE_W-1:0] pos_ff, probe_addr, cur_pos_ff;
   logic [SIZE_W:0]   right_pos;
   offset_type        off_ff;
   logic [IDX_W-1:0]  clr_ff;
   logic [AW-1:0]     probe_wide, cur_wide;
   logic [IDX_W-1:0]  mem_addr;
   logic [KEY_W:0]    mem [TABLE_SIZE];
   logic [KEY_W:0]    rd_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   // size in use: zero reads as one, saturate at the table depth or 2047, whichever is less
   always_comb begin
      if (size_ff == '0) begin
         s_use = SIZE_W'(1);
      end else if (size_ff > SIZE_CAP) begin
         s_use = SIZE_CAP;
      end else begin
         s_use = size_ff;
      end
      half = s_use >> 1;
      last = (ATT_W'(s_use) + (ATT_W'(s_use) << 1)) >> 1;
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   // capture the request
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_data.opcode;
         key_ff <= req_data.key;
      end
   end

   // restoring key mod S, one key bit a cycle; then step the residue per attempt
   assign rem_shift = {rem_ff, kshift_ff[KEY_W-1]};
   assign r_inc     = {1'b0, rem_ff} + (SIZE_W+1)'(1);

   always_comb begin
      if (rem_shift >= {1'b0, s_use}) begin
         rem_in = SIZE_W'(rem_shift - {1'b0, s_use});
      end else begin
         rem_in = rem_shift[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         kshift_ff <= key_ff;
         rem_ff    <= '0;
         dcnt_ff   <= '0;
         a_ff      <= '0;
      end else if (cmd.div_step) begin
         kshift_ff <= {kshift_ff[KEY_W-2:0], 1'b0};
         rem_ff    <= rem_in;
         dcnt_ff   <= dcnt_ff + DCNT_W'(1);
      end else if (cmd.advance) begin
         a_ff   <= a_ff + ATT_W'(1);
         rem_ff <= (r_inc == {1'b0, s_use}) ? '0 : r_inc[SIZE_W-1:0];
      end
   end

   // multiplicative hash, one product per stage
   assign ka_full   = {13'b0, key_ff} * {31'b0, a_ff};
   assign frac_full = {32'b0, ka_ff} * {32'b0, PHI_INV_Q32};
   assign pos_full  = {32'b0, s_use} * {11'b0, frac_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         ka_ff <= ka_full[31:0];
      end
      if (cmd.mul2) begin
         frac_ff <= frac_full[31:0];
      end
      if (cmd.mul3) begin
         pos_ff <= ({2'b0, half} > a_ff) ? pos_full[42:32] : rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= OFF_CENTRE;
      end else if (cmd.off_load) begin
         off_ff <= cmd.off_value;
      end
   end

   // probe address for the current offset
   assign right_pos = {1'b0, pos_ff} + (SIZE_W+1)'(1);

   always_comb begin
      case (off_ff)
         OFF_RIGHT: probe_addr = right_pos[SIZE_W-1:0];
         OFF_LEFT:  probe_addr = pos_ff - SIZE_W'(1);
         default:   probe_addr = pos_ff;
      endcase
   end

   assign probe_wide = AW'(probe_addr);
   assign cur_wide   = AW'(cur_pos_ff);

   // clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= (clr_ff == CLR_LAST) ? '0 : clr_ff + IDX_W'(1);
      end
   end

   // slot memory: one write, one registered read
   always_comb begin
      if (cmd.clr_step) begin
         mem_addr = clr_ff;
      end else if (cmd.mem_wr_key) begin
         mem_addr = cur_wide[IDX_W-1:0];
      end else begin
         mem_addr = probe_wide[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         mem[mem_addr] <= '0;
      end else if (cmd.mem_wr_key) begin
         mem[mem_addr] <= {1'b1, key_ff};
      end
      if (cmd.mem_rd) begin
         rd_ff      <= mem[mem_addr];
         cur_pos_ff <= probe_addr;
      end
   end

   // output beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.success  <= cmd.rsp_ok;
         rsp_ff.position <= cmd.rsp_pos ? cur_pos_ff[POS_W-1:0] : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status back to the controller
   always_comb begin
      status.op           = op_ff;
      status.clr_last     = (clr_ff == CLR_LAST);
      status.div_last     = (dcnt_ff == DIV_LAST);
      status.match        = (op_ff == OP_INSERT) ? !rd_ff[KEY_W]
                            : (rd_ff[KEY_W] && (rd_ff[KEY_W-1:0] == key_ff));
      status.has_right    = (right_pos < {1'b0, s_use});
      status.has_left     = (pos_ff != '0);
      status.last_attempt = (a_ff == last);
      status.off          = off_ff;
      status.rsp_busy     = rsp_valid_ff && rsp_stall;
   end

endmodule

// File: hdl/pht_ctrl.sv
// ----------------------------------------------------------------------------
// pht_ctrl: sequencing state machine of the probing hash table
// Runs the reset sweep, dispatches opcodes, steps the divider and the probe
// attempts, and hands the outcome to the output register.
// ----------------------------------------------------------------------------
module pht_ctrl
   import pht_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [11:0] {
      ST_INIT     = 12'b000000000001,
      ST_IDLE     = 12'b000000000010,
      ST_DISPATCH = 12'b000000000100,
      ST_CLEAR    = 12'b000000001000,
      ST_DIV      = 12'b000000010000,
      ST_ADVANCE  = 12'b000000100000,
      ST_MUL1     = 12'b000001000000,
      ST_MUL2     = 12'b000010000000,
      ST_MUL3     = 12'b000100000000,
      ST_READ     = 12'b001000000000,
      ST_CHECK    = 12'b010000000000,
      ST_FINISH   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      ok_ff, ok_in;
   logic      pos_ff, pos_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ok_in    = ok_ff;
      pos_in   = pos_ff;
      cmd      = '0;
      cmd.off_value = OFF_CENTRE;
      unique case (state_ff)
         // sweep every slot empty after reset
         ST_INIT: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.op) inside
               OP_CLEAR: begin
                  state_in = ST_CLEAR;
               end
               OP_INSERT, OP_SEARCH: begin
                  cmd.div_start = 1'b1;
                  state_in = ST_DIV;
               end
               default: begin
                  ok_in    = 1'b0;
                  pos_in   = 1'b0;
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               ok_in    = 1'b1;
               pos_in   = 1'b0;
               state_in = ST_FINISH;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul3      = 1'b1;
            cmd.off_load  = 1'b1;
            cmd.off_value = OFF_CENTRE;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in = ST_CHECK;
         end
         // hit, then neighbours, then next attempt, or a miss after the last attempt
         ST_CHECK: begin
            if (status.match) begin
               cmd.mem_wr_key = (status.op == OP_INSERT);
               ok_in    = 1'b1;
               pos_in   = 1'b1;
               state_in = ST_FINISH;
            end else if (status.off == OFF_CENTRE && status.has_right) begin
               cmd.off_load  = 1'b1;
               cmd.off_value = OFF_RIGHT;
               state_in = ST_READ;
            end else if (status.off != OFF_LEFT && status.has_left) begin
               cmd.off_load  = 1'b1;
               cmd.off_value = OFF_LEFT;
               state_in = ST_READ;
            end else if (status.last_attempt) begin
               ok_in    = 1'b0;
               pos_in   = 1'b0;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_ADVANCE;
            end
         end
         // hold until the output register is free
         ST_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_ok   = ok_ff;
               cmd.rsp_pos  = pos_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ok_ff    <= 1'b0;
         pos_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ok_ff    <= ok_in;
         pos_ff   <= pos_in;
      end
   end

endmodule
